// ----- rtl/acc_alu_pkg.sv -----
// shared constants, command and status codes, and item types of the accumulator unit
package acc_alu_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W      = $clog2(DATA_W);

    localparam logic [3:0] CMD_CLEAR      = 4'd0;
    localparam logic [3:0] CMD_LOAD       = 4'd1;
    localparam logic [3:0] CMD_PUSH       = 4'd2;
    localparam logic [3:0] CMD_POP        = 4'd3;
    localparam logic [3:0] CMD_READ_STEP  = 4'd4;
    localparam logic [3:0] CMD_SET_STEP   = 4'd5;
    localparam logic [3:0] CMD_SET_LIMIT  = 4'd6;
    localparam logic [3:0] CMD_READ_LIMIT = 4'd7;
    localparam logic [3:0] CMD_INC        = 4'd8;
    localparam logic [3:0] CMD_DEC        = 4'd9;
    localparam logic [3:0] CMD_ADD        = 4'd10;
    localparam logic [3:0] CMD_SUB        = 4'd11;
    localparam logic [3:0] CMD_MUL        = 4'd12;
    localparam logic [3:0] CMD_DIV        = 4'd13;
    localparam logic [3:0] CMD_MOD        = 4'd14;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic [3:0]               command;
        logic signed [DATA_W-1:0] operand;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [1:0]               status;
        logic                     flags_valid;
        logic [5:0]               compare_flags;
        logic                     stack_empty;
    } t_out_item;

    // eq, ne, gt, lt, ge, le against zero, bit 0 first
    function automatic logic [5:0] zero_flags(input logic [DATA_W-1:0] v);
        logic eq;
        logic lt;
        logic gt;
        eq = (v == '0);
        lt = v[DATA_W-1];
        gt = !eq && !lt;
        return {!gt, !lt, lt, gt, !eq, eq};
    endfunction

endpackage

// ----- rtl/accumulator_alu_with_stack.sv -----
// accumulator unit with save stack and one shared adder for all arithmetic
// each item passes EXEC and DONE; pop adds POP, multiply adds ITER, and divide and
// remainder add ABSB, ITER and FIX; no new item is taken until DONE has passed its result on
// multiply, divide and remainder run 32 passes of the single shared adder
// (shift-add or restoring subtract); an output stall holds the unit in DONE
// synchronous active-low reset clears accumulator, step, limit, stack count and valid;
// stack entries hold no value until pushed
module accumulator_alu_with_stack
    import acc_alu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_ABSB = 3'd2;
    localparam logic [2:0] S_ITER = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_POP  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam int SUM_W = DATA_W + 2;

    logic [2:0]          r_state, n_state;
    logic [3:0]          r_cmd, n_cmd;
    logic [DATA_W-1:0]   r_opd, n_opd;
    logic [DATA_W-1:0]   r_acc, n_acc;
    logic [DATA_W-1:0]   r_step, n_step;
    logic [DATA_W-1:0]   r_limit, n_limit;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [DATA_W-1:0]   r_a, n_a;
    logic [DATA_W-1:0]   r_b, n_b;
    logic [DATA_W-1:0]   r_q, n_q;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic                r_an, n_an;
    logic                r_bn, n_bn;
    t_out_item           r_res, n_res;
    t_out_item           r_out;
    logic                r_out_valid;

    logic [3*DATA_W-1:0] r_stack [STACK_DEPTH];
    logic [3*DATA_W-1:0] r_rd;

    logic                w_we;
    logic                w_re;
    logic [STACK_AW-1:0] w_waddr;
    logic [STACK_AW-1:0] w_raddr;
    logic [CNT_W-1:0]    w_cnt_dec;
    logic [3*DATA_W-1:0] w_wdata;
    logic                w_out_free;
    logic                w_load_out;
    t_out_item           w_final;

    // shared adder / subtractor
    logic [DATA_W:0]     u_a;
    logic [DATA_W:0]     u_b;
    logic                u_sub;
    logic [SUM_W-1:0]    u_b_ext;
    logic [SUM_W-1:0]    u_sum;
    logic                u_borrow;

    logic [DATA_W-1:0]   w_pop_acc;
    logic [DATA_W-1:0]   w_pop_step;
    logic [DATA_W-1:0]   w_pop_limit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load_out = (r_state == S_DONE) && w_out_free;
    assign w_cnt_dec  = r_count - 1'b1;
    assign w_waddr    = r_count[STACK_AW-1:0];
    assign w_raddr    = w_cnt_dec[STACK_AW-1:0];
    assign w_wdata    = {r_acc, r_step, r_limit};

    assign w_pop_acc   = r_rd[3*DATA_W-1:2*DATA_W];
    assign w_pop_step  = r_rd[2*DATA_W-1:DATA_W];
    assign w_pop_limit = r_rd[DATA_W-1:0];

    always_comb begin
        w_final             = r_res;
        w_final.stack_empty = (r_count == '0);
    end

    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
        case (r_state)
            S_EXEC: begin
                case (r_cmd)
                    CMD_INC: begin
                        u_a = {1'b0, r_acc};
                        u_b = (DATA_W+1)'(1);
                    end
                    CMD_DEC: begin
                        u_a   = {1'b0, r_acc};
                        u_b   = (DATA_W+1)'(1);
                        u_sub = 1'b1;
                    end
                    CMD_ADD: begin
                        u_a = {1'b0, r_acc};
                        u_b = {1'b0, r_opd};
                    end
                    CMD_SUB: begin
                        u_a   = {1'b0, r_acc};
                        u_b   = {1'b0, r_opd};
                        u_sub = 1'b1;
                    end
                    CMD_READ_STEP: begin
                        u_a = {1'b0, r_acc};
                        u_b = {1'b0, r_step};
                    end
                    CMD_DIV, CMD_MOD: begin
                        // magnitude of the dividend
                        u_b   = {1'b0, r_acc};
                        u_sub = r_acc[DATA_W-1];
                    end
                    default: begin
                        u_a = '0;
                    end
                endcase
            end
            S_ABSB: begin
                u_b   = {1'b0, r_opd};
                u_sub = r_opd[DATA_W-1];
            end
            S_ITER: begin
                if (r_cmd == CMD_MUL) begin
                    u_a = {1'b0, r_a};
                    u_b = r_q[0] ? {1'b0, r_b} : '0;
                end else begin
                    u_a   = {r_a, r_q[DATA_W-1]};
                    u_b   = {1'b0, r_b};
                    u_sub = 1'b1;
                end
            end
            S_FIX: begin
                if (r_cmd == CMD_DIV) begin
                    u_b   = {1'b0, r_q};
                    u_sub = r_an ^ r_bn;
                end else begin
                    u_b   = {1'b0, r_a};
                    u_sub = r_an;
                end
            end
            default: begin
                u_a = '0;
            end
        endcase
    end

    assign u_b_ext  = {1'b0, u_b};
    assign u_sum    = {1'b0, u_a} + (u_sub ? ~u_b_ext : u_b_ext) + SUM_W'(u_sub);
    assign u_borrow = u_sum[SUM_W-1];

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_opd   = r_opd;
        n_acc   = r_acc;
        n_step  = r_step;
        n_limit = r_limit;
        n_count = r_count;
        n_a     = r_a;
        n_b     = r_b;
        n_q     = r_q;
        n_iter  = r_iter;
        n_an    = r_an;
        n_bn    = r_bn;
        n_res   = r_res;
        w_we    = 1'b0;
        w_re    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.command;
                    n_opd   = i_in_data.operand;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res.value_out     = r_acc;
                n_res.status        = ST_OK;
                n_res.flags_valid   = 1'b0;
                n_res.compare_flags = '0;
                n_res.stack_empty   = 1'b0;
                n_state             = S_DONE;
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_acc           = '0;
                        n_step          = '0;
                        n_res.value_out = '0;
                    end
                    CMD_LOAD: begin
                        n_acc           = r_opd;
                        n_res.value_out = r_opd;
                    end
                    CMD_PUSH: begin
                        if (r_count == CNT_W'(STACK_DEPTH)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            w_we            = 1'b1;
                            n_count         = r_count + 1'b1;
                            n_acc           = r_opd;
                            n_res.value_out = r_opd;
                        end
                    end
                    CMD_POP: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_POP;
                        end
                    end
                    CMD_READ_STEP: begin
                        n_acc = u_sum[DATA_W-1:0];
                    end
                    CMD_SET_STEP: begin
                        n_step = r_opd;
                    end
                    CMD_SET_LIMIT: begin
                        n_limit = r_opd;
                    end
                    CMD_READ_LIMIT: begin
                        n_res.value_out = r_limit;
                    end
                    CMD_INC, CMD_DEC, CMD_ADD, CMD_SUB: begin
                        n_acc               = u_sum[DATA_W-1:0];
                        n_res.value_out     = u_sum[DATA_W-1:0];
                        n_res.flags_valid   = 1'b1;
                        n_res.compare_flags = zero_flags(u_sum[DATA_W-1:0]);
                    end
                    CMD_MUL: begin
                        n_a     = '0;
                        n_b     = r_acc;
                        n_q     = r_opd;
                        n_iter  = '0;
                        n_state = S_ITER;
                    end
                    CMD_DIV, CMD_MOD: begin
                        if (r_opd == '0) begin
                            n_res.status = ST_DIVZ;
                        end else begin
                            n_q     = u_sum[DATA_W-1:0];
                            n_a     = '0;
                            n_an    = r_acc[DATA_W-1];
                            n_bn    = r_opd[DATA_W-1];
                            n_state = S_ABSB;
                        end
                    end
                    default: begin
                        n_res.value_out = r_acc;
                    end
                endcase
            end
            S_ABSB: begin
                n_b     = u_sum[DATA_W-1:0];
                n_iter  = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                n_iter = r_iter + 1'b1;
                if (r_cmd == CMD_MUL) begin
                    n_a = u_sum[DATA_W-1:0];
                    n_b = {r_b[DATA_W-2:0], 1'b0};
                    n_q = {1'b0, r_q[DATA_W-1:1]};
                end else begin
                    // restoring step: keep the shifted remainder when the trial goes negative
                    n_a = u_borrow ? u_a[DATA_W-1:0] : u_sum[DATA_W-1:0];
                    n_q = {r_q[DATA_W-2:0], !u_borrow};
                end
                if (r_iter == ITER_W'(DATA_W - 1)) begin
                    if (r_cmd == CMD_MUL) begin
                        n_acc               = u_sum[DATA_W-1:0];
                        n_res.value_out     = u_sum[DATA_W-1:0];
                        n_res.flags_valid   = 1'b1;
                        n_res.compare_flags = zero_flags(u_sum[DATA_W-1:0]);
                        n_state             = S_DONE;
                    end else begin
                        n_state = S_FIX;
                    end
                end
            end
            S_FIX: begin
                // sign correction of quotient or remainder
                n_acc               = u_sum[DATA_W-1:0];
                n_res.value_out     = u_sum[DATA_W-1:0];
                n_res.flags_valid   = 1'b1;
                n_res.compare_flags = zero_flags(u_sum[DATA_W-1:0]);
                n_state             = S_DONE;
            end
            S_POP: begin
                n_acc             = w_pop_acc;
                n_step            = w_pop_step;
                n_limit           = w_pop_limit;
                n_count           = w_cnt_dec;
                n_res.value_out   = r_acc;
                n_res.flags_valid = (w_pop_step != '0);
                n_res.compare_flags = (w_pop_step != '0) ? zero_flags(w_pop_acc) : '0;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_step      <= '0;
            r_limit     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_step  <= n_step;
            r_limit <= n_limit;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_opd  <= n_opd;
        r_a    <= n_a;
        r_b    <= n_b;
        r_q    <= n_q;
        r_iter <= n_iter;
        r_an   <= n_an;
        r_bn   <= n_bn;
        r_res  <= n_res;
        if (w_load_out) begin
            r_out <= w_final;
        end
    end

    // save stack: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_stack[w_raddr];
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted item did not start execution");

    a_empty_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (o_out_data.stack_empty == (r_count == '0)))
        else $error("stack_empty disagrees with stack count");

    a_no_flags_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.flags_valid) |-> (o_out_data.compare_flags == '0))
        else $error("compare flags set without flags_valid");

    a_divz_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_DIVZ) |-> !o_out_data.flags_valid)
        else $error("flags reported on divide by zero");

endmodule
